>>> hw/rtl/psd_pkg.sv
package psd_pkg;

    localparam int PC_W       = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int READ_W     = 16;
    localparam int DB_W       = 15;
    localparam int GAIN_W     = 12;
    localparam int TICK_W     = 32;
    localparam int LONG_W     = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_REFERENCE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D    = 3'd4;

    localparam logic [DB_W-1:0]   DEADBAND_RST = 15'd82;
    localparam logic [GAIN_W-1:0] GAIN_P_RST   = 12'd640;
    localparam logic [GAIN_W-1:0] GAIN_I_RST   = 12'd256;
    localparam logic [GAIN_W-1:0] GAIN_D_RST   = 12'd1024;

    localparam logic [PC_W-1:0] ST_IDLE    = 4'd0;
    localparam logic [PC_W-1:0] ST_SAT     = 4'd1;
    localparam logic [PC_W-1:0] ST_DBAND   = 4'd2;
    localparam logic [PC_W-1:0] ST_DIFF    = 4'd3;
    localparam logic [PC_W-1:0] ST_DIVINIT = 4'd4;
    localparam logic [PC_W-1:0] ST_DIVSTEP = 4'd5;
    localparam logic [PC_W-1:0] ST_DIVFIX  = 4'd6;
    localparam logic [PC_W-1:0] ST_MULP    = 4'd7;
    localparam logic [PC_W-1:0] ST_MULI    = 4'd8;
    localparam logic [PC_W-1:0] ST_MULD    = 4'd9;
    localparam logic [PC_W-1:0] ST_ACCD    = 4'd10;
    localparam logic [PC_W-1:0] ST_STEER   = 4'd11;
    localparam logic [PC_W-1:0] ST_TURN    = 4'd12;
    localparam logic [PC_W-1:0] ST_WAIT    = 4'd13;
    localparam logic [PC_W-1:0] ST_EMIT    = 4'd14;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_NOP,
        OP_SAT,
        OP_DBAND,
        OP_DIFF,
        OP_DIVINIT,
        OP_DIVSTEP,
        OP_DIVFIX,
        OP_STEER,
        OP_TURN,
        OP_EMIT
    } t_op;

    typedef enum logic [1:0] {
        MS_NONE,
        MS_P,
        MS_I,
        MS_D
    } t_msel;

    typedef enum logic [1:0] {
        AC_HOLD,
        AC_LOAD,
        AC_ADD
    } t_acc;

    typedef enum logic [2:0] {
        CD_NEXT,
        CD_ALWAYS,
        CD_NO_ITEM,
        CD_STOPPED,
        CD_DIV_MORE,
        CD_OUT_BUSY
    } t_cond;

    typedef struct packed {
        t_op             op;
        t_msel           msel;
        t_acc            acc;
        t_cond           cond;
        logic [PC_W-1:0] target;
    } t_uword;

    typedef struct packed {
        logic no_item;
        logic stopped;
        logic div_more;
        logic out_busy;
    } t_flags;

    typedef struct packed {
        logic signed [READ_W-1:0] reference;
        logic [DB_W-1:0]          deadband;
        logic [GAIN_W-1:0]        gain_p;
        logic [GAIN_W-1:0]        gain_i;
        logic [GAIN_W-1:0]        gain_d;
    } t_cfg;

endpackage

>>> hw/rtl/psd_div.sv
module psd_div #(
    parameter int DW = 17
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  logic          i_step,
    input  logic [DW-1:0] i_dividend,
    input  logic [31:0]   i_divisor,
    output logic [DW-1:0] o_quotient,
    output logic          o_more
);

    localparam int CNT_W = $clog2(DW + 1);

    logic [31:0]      r_rem;
    logic [DW-1:0]    r_quo;
    logic [CNT_W-1:0] r_cnt;
    logic [32:0]      w_trial;
    logic [32:0]      w_sub;
    logic             w_ge;

    assign w_trial = {r_rem, r_quo[DW-1]};
    assign w_ge    = w_trial >= {1'b0, i_divisor};
    assign w_sub   = w_trial - {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= CNT_W'(DW);
        end else if (i_step) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (i_step) begin
            r_rem <= w_ge ? w_sub[31:0] : w_trial[31:0];
            r_quo <= {r_quo[DW-2:0], w_ge};
        end
    end

    assign o_quotient = r_quo;
    assign o_more     = r_cnt != CNT_W'(1);

endmodule

>>> hw/rtl/psd_dpath.sv
module psd_dpath
    import psd_pkg::*;
#(
    parameter int SW = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_uword                   i_uw,
    input  t_cfg                     i_cfg,
    input  logic                     i_accept,
    input  logic signed [READ_W-1:0] i_sensor_reading,
    input  logic [TICK_W-1:0]        i_timestamp,
    input  logic                     i_vehicle_stopped,
    output logic                     o_stopped,
    output logic                     o_div_more,
    output logic signed [LONG_W-1:0] o_turn
);

    localparam int DW = SW + 1;
    localparam int CW = (SW > READ_W + 1) ? SW : READ_W + 1;
    localparam int MW = (SW > DB_W) ? SW : DB_W;
    localparam int BW = (DW > LONG_W) ? DW : LONG_W;
    localparam int PW = BW + GAIN_W + 1;
    localparam int SHW = PW - 8;
    localparam int AW = SHW + 2;

    localparam logic signed [CW-1:0] SMAX = {{(CW - SW + 1){1'b0}}, {(SW - 1){1'b1}}};
    localparam logic signed [CW-1:0] SMIN = {{(CW - SW + 1){1'b1}}, {(SW - 1){1'b0}}};
    localparam logic signed [AW-1:0] LMAX = {{(AW - 31){1'b0}}, {31{1'b1}}};
    localparam logic signed [AW-1:0] LMIN = {{(AW - 31){1'b1}}, {31{1'b0}}};

    function automatic logic signed [LONG_W-1:0] sat33(input logic signed [LONG_W:0] v);
        logic signed [LONG_W-1:0] res;
        if (v[LONG_W] != v[LONG_W-1]) begin
            res = v[LONG_W] ? {1'b1, {(LONG_W - 1){1'b0}}} : {1'b0, {(LONG_W - 1){1'b1}}};
        end else begin
            res = v[LONG_W-1:0];
        end
        return res;
    endfunction

    logic signed [READ_W-1:0] r_reading;
    logic [TICK_W-1:0]        r_tick;
    logic                     r_stopped;

    logic signed [SW-1:0]     r_err;
    logic [TICK_W-1:0]        r_gap;
    logic signed [DW-1:0]     r_diff;
    logic                     r_neg;
    logic signed [DW-1:0]     r_deriv;
    logic signed [PW-1:0]     r_prod;
    logic signed [AW-1:0]     r_acc;
    logic signed [LONG_W-1:0] r_steer;
    logic signed [LONG_W-1:0] r_turn;

    logic signed [SW-1:0]     r_prev_err;
    logic signed [LONG_W-1:0] r_sum;
    logic signed [LONG_W-1:0] r_prev_steer;
    logic [TICK_W-1:0]        r_prev_tick;

    logic signed [READ_W:0]   w_raw;
    logic signed [CW-1:0]     w_raw_x;
    logic signed [CW-1:0]     w_sat;
    logic [TICK_W-1:0]        w_gap;
    logic [SW-1:0]            w_mag;
    logic signed [LONG_W:0]   w_sum_x;
    logic signed [LONG_W:0]   w_turn_x;
    logic [DW-1:0]            w_dmag;
    logic [DW-1:0]            w_quo;
    logic signed [GAIN_W:0]   w_mop_a;
    logic signed [BW-1:0]     w_mop_b;
    logic signed [SHW-1:0]    w_sh;
    logic signed [LONG_W-1:0] w_steer;

    assign w_raw   = (READ_W + 1)'(i_cfg.reference) - (READ_W + 1)'(r_reading);
    assign w_raw_x = CW'(w_raw);
    assign w_gap   = r_tick - r_prev_tick;
    assign w_mag   = r_err[SW-1] ? SW'(-r_err) : SW'(r_err);
    assign w_sum_x = (LONG_W + 1)'(r_sum) + (LONG_W + 1)'(r_err);
    assign w_turn_x = (LONG_W + 1)'(r_steer) - (LONG_W + 1)'(r_prev_steer);
    assign w_dmag  = r_diff[DW-1] ? DW'(-r_diff) : DW'(r_diff);
    assign w_sh    = SHW'(r_prod >>> 8);

    always_comb begin
        if (w_raw_x > SMAX) begin
            w_sat = SMAX;
        end else if (w_raw_x < SMIN) begin
            w_sat = SMIN;
        end else begin
            w_sat = w_raw_x;
        end
    end

    always_comb begin
        if (r_acc > LMAX) begin
            w_steer = LMAX[LONG_W-1:0];
        end else if (r_acc < LMIN) begin
            w_steer = LMIN[LONG_W-1:0];
        end else begin
            w_steer = r_acc[LONG_W-1:0];
        end
    end

    always_comb begin
        case (i_uw.msel)
            MS_P: begin
                w_mop_a = {1'b0, i_cfg.gain_p};
                w_mop_b = BW'(r_err);
            end
            MS_I: begin
                w_mop_a = {1'b0, i_cfg.gain_i};
                w_mop_b = BW'(r_sum);
            end
            MS_D: begin
                w_mop_a = {1'b0, i_cfg.gain_d};
                w_mop_b = BW'(r_deriv);
            end
            default: begin
                w_mop_a = '0;
                w_mop_b = '0;
            end
        endcase
    end

    psd_div #(
        .DW(DW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (i_uw.op == OP_DIVINIT),
        .i_step     (i_uw.op == OP_DIVSTEP),
        .i_dividend (w_dmag),
        .i_divisor  (r_gap),
        .o_quotient (w_quo),
        .o_more     (o_div_more)
    );

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_reading <= i_sensor_reading;
            r_tick    <= i_timestamp;
            r_stopped <= i_vehicle_stopped;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_uw.op)
            OP_SAT: begin
                r_err <= SW'(w_sat);
                r_gap <= (w_gap == '0) ? TICK_W'(1) : w_gap;
            end
            OP_DBAND: begin
                if (MW'(w_mag) < MW'(i_cfg.deadband)) begin
                    r_err <= '0;
                end
            end
            OP_DIFF: begin
                r_diff <= DW'(r_err) - DW'(r_prev_err);
            end
            OP_DIVINIT: begin
                r_neg <= r_diff[DW-1];
            end
            OP_DIVFIX: begin
                r_deriv <= r_neg ? -signed'(w_quo) : signed'(w_quo);
            end
            OP_STEER: begin
                r_steer <= w_steer;
            end
            OP_TURN: begin
                r_turn <= sat33(w_turn_x);
            end
            default: begin
            end
        endcase
        if (i_uw.msel != MS_NONE) begin
            r_prod <= PW'(w_mop_a) * PW'(w_mop_b);
        end
        case (i_uw.acc)
            AC_LOAD: r_acc <= AW'(w_sh);
            AC_ADD:  r_acc <= r_acc + AW'(w_sh);
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_err   <= '0;
            r_sum        <= '0;
            r_prev_steer <= '0;
            r_prev_tick  <= '0;
        end else begin
            if (i_uw.op == OP_DIFF) begin
                r_sum <= sat33(w_sum_x);
            end
            if (i_uw.op == OP_EMIT) begin
                r_prev_err   <= r_err;
                r_prev_steer <= r_steer;
                r_prev_tick  <= r_tick;
            end
        end
    end

    assign o_stopped = r_stopped;
    assign o_turn    = r_turn;

endmodule

>>> hw/rtl/psd_seq.sv
module psd_seq
    import psd_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_flags i_flags,
    output t_uword o_uw
);

    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    t_uword          w_uw;
    logic            w_take;

    always_comb begin
        unique case (r_pc)
            ST_IDLE:    w_uw = '{OP_IDLE,    MS_NONE, AC_HOLD, CD_NO_ITEM,  ST_IDLE};
            ST_SAT:     w_uw = '{OP_SAT,     MS_NONE, AC_HOLD, CD_STOPPED,  ST_IDLE};
            ST_DBAND:   w_uw = '{OP_DBAND,   MS_NONE, AC_HOLD, CD_NEXT,     ST_IDLE};
            ST_DIFF:    w_uw = '{OP_DIFF,    MS_NONE, AC_HOLD, CD_NEXT,     ST_IDLE};
            ST_DIVINIT: w_uw = '{OP_DIVINIT, MS_NONE, AC_HOLD, CD_NEXT,     ST_IDLE};
            ST_DIVSTEP: w_uw = '{OP_DIVSTEP, MS_NONE, AC_HOLD, CD_DIV_MORE, ST_DIVSTEP};
            ST_DIVFIX:  w_uw = '{OP_DIVFIX,  MS_NONE, AC_HOLD, CD_NEXT,     ST_IDLE};
            ST_MULP:    w_uw = '{OP_NOP,     MS_P,    AC_HOLD, CD_NEXT,     ST_IDLE};
            ST_MULI:    w_uw = '{OP_NOP,     MS_I,    AC_LOAD, CD_NEXT,     ST_IDLE};
            ST_MULD:    w_uw = '{OP_NOP,     MS_D,    AC_ADD,  CD_NEXT,     ST_IDLE};
            ST_ACCD:    w_uw = '{OP_NOP,     MS_NONE, AC_ADD,  CD_NEXT,     ST_IDLE};
            ST_STEER:   w_uw = '{OP_STEER,   MS_NONE, AC_HOLD, CD_NEXT,     ST_IDLE};
            ST_TURN:    w_uw = '{OP_TURN,    MS_NONE, AC_HOLD, CD_NEXT,     ST_IDLE};
            ST_WAIT:    w_uw = '{OP_NOP,     MS_NONE, AC_HOLD, CD_OUT_BUSY, ST_WAIT};
            ST_EMIT:    w_uw = '{OP_EMIT,    MS_NONE, AC_HOLD, CD_ALWAYS,   ST_IDLE};
            default:    w_uw = '{OP_NOP,     MS_NONE, AC_HOLD, CD_ALWAYS,   ST_IDLE};
        endcase
    end

    always_comb begin
        unique case (w_uw.cond)
            CD_NEXT:     w_take = 1'b0;
            CD_ALWAYS:   w_take = 1'b1;
            CD_NO_ITEM:  w_take = i_flags.no_item;
            CD_STOPPED:  w_take = i_flags.stopped;
            CD_DIV_MORE: w_take = i_flags.div_more;
            CD_OUT_BUSY: w_take = i_flags.out_busy;
            default:     w_take = 1'b1;
        endcase
        n_pc = w_take ? w_uw.target : r_pc + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= ST_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_uw = w_uw;

endmodule

>>> hw/rtl/pid_steering_delta_top.sv
// Channel   Direction  Handshake                 Word
// input     in         i_in_valid / o_in_stall   sensor_reading, timestamp, vehicle_stopped
// output    out        o_out_valid / i_out_stall turn_delta
// config    in         i_cfg_valid / o_cfg_ready register index, write data
//
// A word that produces a result passes through all sequencer steps before the next acceptance;
// the serial divider, one quotient bit per cycle, is the longest of them.
// A word with vehicle_stopped set is dropped at the saturate step and the block returns to idle.
// Reset is synchronous and active low; it restores the register defaults and clears state.
// A stalled output holds the sequencer at its wait step, just before the result register
// is loaded, until the waiting word is taken.
module pid_steering_delta_top
    import psd_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic signed [READ_W-1:0]     i_sensor_reading,
    input  logic [TICK_W-1:0]            i_timestamp,
    input  logic                         i_vehicle_stopped,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic signed [LONG_W-1:0]     o_turn_delta,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data
);

    t_cfg                     r_cfg;
    logic                     r_out_valid;
    logic signed [LONG_W-1:0] r_turn_delta;
    t_uword                   w_uw;
    t_flags                   w_flags;
    logic                     w_accept;
    logic                     w_stopped;
    logic                     w_div_more;
    logic signed [LONG_W-1:0] w_turn;

    assign o_in_stall  = w_uw.op != OP_IDLE;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    assign w_flags.no_item  = !i_in_valid;
    assign w_flags.stopped  = w_stopped;
    assign w_flags.div_more = w_div_more;
    assign w_flags.out_busy = r_out_valid && i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reference <= '0;
            r_cfg.deadband  <= DEADBAND_RST;
            r_cfg.gain_p    <= GAIN_P_RST;
            r_cfg.gain_i    <= GAIN_I_RST;
            r_cfg.gain_d    <= GAIN_D_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_REFERENCE: r_cfg.reference <= i_cfg_data;
                CFG_DEADBAND:  r_cfg.deadband  <= i_cfg_data[DB_W-1:0];
                CFG_GAIN_P:    r_cfg.gain_p    <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_I:    r_cfg.gain_i    <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_D:    r_cfg.gain_d    <= i_cfg_data[GAIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    psd_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .o_uw    (w_uw)
    );

    psd_dpath #(
        .SW(SAMPLE_WIDTH)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_uw              (w_uw),
        .i_cfg             (r_cfg),
        .i_accept          (w_accept),
        .i_sensor_reading  (i_sensor_reading),
        .i_timestamp       (i_timestamp),
        .i_vehicle_stopped (i_vehicle_stopped),
        .o_stopped         (w_stopped),
        .o_div_more        (w_div_more),
        .o_turn            (w_turn)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_uw.op == OP_EMIT) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_uw.op == OP_EMIT) begin
            r_turn_delta <= w_turn;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_turn_delta = r_turn_delta;

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (w_uw.op == OP_SAT))
        else $error("Accepted word did not start the program.");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_uw.op == OP_EMIT) |-> !(r_out_valid && i_out_stall))
        else $error("Result written over a word still waiting at the output.");

    a_stopped_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_uw.op == OP_SAT) && w_stopped) |=> (w_uw.op == OP_IDLE))
        else $error("Stopped-vehicle word was not dropped.");

endmodule

>>> sim/pid_steering_delta_top_tb.sv
`timescale 1ns / 1ps

module pid_steering_delta_top_tb;
    import psd_pkg::*;

    localparam int SAMPLE_W = 16;
    localparam int SETTLE = 2 * (SAMPLE_W + 15);
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_WORDS = 130;
    localparam longint LONG_MAX = 64'sd2147483647;
    localparam longint LONG_MIN = -64'sd2147483648;
    localparam longint ERR_MAX = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
    localparam longint ERR_MIN = -ERR_MAX - 1;

    typedef struct {
        logic signed [READ_W-1:0] reading;
        logic [TICK_W-1:0]        stamp;
        logic                     stopped;
    } t_sample;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_in_valid = 1'b0;
    logic signed [READ_W-1:0]  i_sensor_reading = '0;
    logic [TICK_W-1:0]         i_timestamp = '0;
    logic                      i_vehicle_stopped = 1'b0;
    logic                      i_out_stall = 1'b0;
    logic                      i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]      i_cfg_index = CFG_REFERENCE;
    logic [CFG_DATA_W-1:0]     i_cfg_data = '0;
    logic                      o_in_stall;
    logic                      o_out_valid;
    logic signed [LONG_W-1:0]  o_turn_delta;
    logic                      o_cfg_ready;

    t_sample                   readings_due[$];
    logic signed [LONG_W-1:0]  turn_deltas_due[$];
    t_cfg                      steer_cfg = '{reference: '0, deadband: DEADBAND_RST,
                                             gain_p: GAIN_P_RST, gain_i: GAIN_I_RST,
                                             gain_d: GAIN_D_RST};
    logic signed [SAMPLE_W-1:0] err_prev = '0;
    logic signed [LONG_W-1:0]   err_sum = '0;
    logic signed [LONG_W-1:0]   steer_prev = '0;
    logic [TICK_W-1:0]          tick_prev = '0;
    logic [TICK_W-1:0]          tick_now = '0;
    logic                       calm = 1'b0;
    logic                       squeeze_go = 1'b0;
    logic                       hold_off = 1'b0;
    int                         fails = 0;

    pid_steering_delta_top #(.SAMPLE_WIDTH(SAMPLE_W)) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_sensor_reading(i_sensor_reading),
        .i_timestamp(i_timestamp),
        .i_vehicle_stopped(i_vehicle_stopped),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_turn_delta(o_turn_delta),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic bit predict_turn(input logic signed [READ_W-1:0] reading,
                                        input logic [TICK_W-1:0] stamp,
                                        input logic stopped,
                                        output logic signed [LONG_W-1:0] delta);
        longint err, mag, deriv, steer;
        logic [TICK_W-1:0] span;
        delta = '0;
        if (stopped) return 1'b0;
        err = clamp(longint'($signed(steer_cfg.reference)) - longint'(reading), ERR_MIN, ERR_MAX);
        mag = (err < 0) ? -err : err;
        if (mag < longint'(steer_cfg.deadband)) err = 0;
        span = stamp - tick_prev;
        if (span == '0) span = 1;
        deriv = (err - longint'(err_prev)) / longint'(span);
        err_sum = LONG_W'(clamp(longint'(err_sum) + err, LONG_MIN, LONG_MAX));
        steer = ((longint'(steer_cfg.gain_p) * err) >>> 8)
              + ((longint'(steer_cfg.gain_i) * longint'(err_sum)) >>> 8)
              + ((longint'(steer_cfg.gain_d) * deriv) >>> 8);
        steer = clamp(steer, LONG_MIN, LONG_MAX);
        delta = LONG_W'(clamp(steer - longint'(steer_prev), LONG_MIN, LONG_MAX));
        err_prev = SAMPLE_W'(err);
        steer_prev = LONG_W'(steer);
        tick_prev = stamp;
        return 1'b1;
    endfunction

    function automatic void queue_reading(input logic signed [READ_W-1:0] rd,
                                          input logic [TICK_W-1:0] step,
                                          input logic stop);
        t_sample s;
        tick_now += step;
        s.reading = rd;
        s.stamp = tick_now;
        s.stopped = stop;
        readings_due.push_back(s);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] gain_pick();
        case ($urandom_range(0, 3))
            0: return {4'($urandom), 12'hFFF};
            1: return {4'($urandom), 12'h000};
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(negedge i_clk); while (!o_cfg_ready);
        @(posedge i_clk);
        case (idx)
            CFG_REFERENCE: steer_cfg.reference = data;
            CFG_DEADBAND:  steer_cfg.deadband = data[DB_W-1:0];
            CFG_GAIN_P:    steer_cfg.gain_p = data[GAIN_W-1:0];
            CFG_GAIN_I:    steer_cfg.gain_i = data[GAIN_W-1:0];
            CFG_GAIN_D:    steer_cfg.gain_d = data[GAIN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic write_settings(input logic [CFG_DATA_W-1:0] ref_v,
                                  input logic [CFG_DATA_W-1:0] db_v,
                                  input logic [CFG_DATA_W-1:0] gp_v,
                                  input logic [CFG_DATA_W-1:0] gi_v,
                                  input logic [CFG_DATA_W-1:0] gd_v,
                                  input bit junk);
        int idx;
        cfg_write(CFG_REFERENCE, ref_v);
        cfg_write(CFG_DEADBAND, db_v);
        cfg_write(CFG_GAIN_P, gp_v);
        cfg_write(CFG_GAIN_I, gi_v);
        cfg_write(CFG_GAIN_D, gd_v);
        if (junk) begin
            for (idx = int'(CFG_GAIN_D) + 1; idx < (1 << CFG_IDX_W); idx++) begin
                cfg_write(CFG_IDX_W'(idx), 16'($urandom));
            end
        end
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic drain();
        while (readings_due.size() != 0 || i_in_valid || turn_deltas_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : drive
        logic signed [LONG_W-1:0] delta;
        t_sample nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                if (predict_turn(i_sensor_reading, i_timestamp, i_vehicle_stopped, delta)) begin
                    turn_deltas_due.push_back(delta);
                end
            end
            if (!i_in_valid || !o_in_stall) begin
                if (readings_due.size() != 0 && (calm || $urandom_range(0, 99) >= 24)) begin
                    nxt = readings_due.pop_front();
                    i_in_valid <= 1'b1;
                    i_sensor_reading <= nxt.reading;
                    i_timestamp <= nxt.stamp;
                    i_vehicle_stopped <= nxt.stopped;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : watch
        logic signed [LONG_W-1:0] want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (turn_deltas_due.size() == 0) begin
                $error("turn_delta: no word expected, actual %0d", o_turn_delta);
                fails++;
            end else begin
                want = turn_deltas_due.pop_front();
                if (o_turn_delta !== want) begin
                    $error("turn_delta: expected %0d, actual %0d", want, o_turn_delta);
                    fails++;
                end
            end
        end
        i_out_stall <= hold_off || (!calm && $urandom_range(0, 99) < 24);
    end

    // The output is held off for a long stretch so that the input backs up.
    initial begin
        wait (squeeze_go);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin
        #10_000_000;
        $display("pid_steering_delta_top_tb NOT OK");
        $finish;
    end

    initial begin : stimulus
        logic signed [READ_W-1:0] rd;
        logic [TICK_W-1:0]        step;
        logic [CFG_DATA_W-1:0]    ref_v;
        logic [CFG_DATA_W-1:0]    db_v;
        logic                     stop;
        int                       ph, made, span, off, r, n;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Default settings: errors at and just inside the deadband, error clamping,
        // a repeated timestamp, a stopped vehicle, tick wraparound and the widest gap.
        queue_reading(16'sd0, 32'd5, 1'b0);
        queue_reading(-16'sd82, 32'd3, 1'b0);
        queue_reading(-16'sd81, 32'd1, 1'b0);
        queue_reading(16'sd82, 32'd2, 1'b0);
        queue_reading(16'sh8000, 32'd1, 1'b0);
        queue_reading(16'sh7FFF, 32'd0, 1'b0);
        queue_reading(16'sd100, 32'd7, 1'b1);
        queue_reading(-16'sd5000, 32'd4, 1'b0);
        queue_reading(-16'sd200, 32'hFFFF_FFF8 - tick_now, 1'b0);
        queue_reading(16'sd300, 32'd16, 1'b0);
        queue_reading(-16'sd1000, 32'hFFFF_FFFF, 1'b0);
        drain();

        write_settings(16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        queue_reading(16'sh7FFF, 32'd1, 1'b0);
        queue_reading(16'sh8000, 32'd1, 1'b0);
        queue_reading(16'sd0, 32'd1, 1'b0);
        queue_reading(16'sd1, 32'd2, 1'b0);
        drain();

        write_settings(16'h7FFF, 16'h7FFF, 16'hF000, 16'h0FFF, 16'h0000, 1'b0);
        queue_reading(16'sh8000, 32'd1, 1'b0);
        queue_reading(16'sd0, 32'd1, 1'b0);
        queue_reading(16'sd1, 32'd1, 1'b0);
        queue_reading(16'sh7FFF, 32'd3, 1'b0);
        drain();

        for (ph = 0; ph < 6; ph++) begin
            case ($urandom_range(0, 3))
                0: ref_v = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
                1: ref_v = 16'(int'($urandom_range(0, 4000)) - 2000);
                default: ref_v = 16'($urandom);
            endcase
            case ($urandom_range(0, 4))
                0: db_v = $urandom_range(0, 1) ? 16'h7FFF : 16'h0000;
                1: db_v = 16'($urandom);
                default: db_v = {1'($urandom), 15'($urandom_range(0, 400))};
            endcase
            write_settings(ref_v, db_v, gain_pick(), gain_pick(), gain_pick(), ph % 2 == 1);
            calm = (ph == 2);
            made = 0;
            while (made < PHASE_WORDS) begin
                span = int'(steer_cfg.deadband) + 8;
                r = $urandom_range(0, 99);
                if (r < 10) begin
                    rd = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                end else if (r < 50) begin
                    off = int'($urandom_range(0, 2 * span)) - span;
                    rd = 16'(int'($signed(steer_cfg.reference)) + off);
                end else if (r < 65) begin
                    off = int'($urandom_range(0, 1200)) - 600;
                    rd = 16'(int'($signed(steer_cfg.reference)) + off);
                end else begin
                    rd = 16'($urandom);
                end
                r = $urandom_range(0, 99);
                if (r < 8) step = '0;
                else if (r < 73) step = $urandom_range(1, 32);
                else if (r < 90) step = $urandom_range(33, 65535);
                else step = $urandom;
                stop = ($urandom_range(0, 99) < 7);
                queue_reading(rd, step, stop);
                if (!stop) made++;
            end
            if (ph == 4) squeeze_go = 1'b1;
            drain();
        end

        calm = 1'b0;
        for (n = 0; n < 4000 && turn_deltas_due.size() != 0; n++) @(negedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (turn_deltas_due.size() != 0) begin
            $error("turn_delta: %0d expected words never arrived", turn_deltas_due.size());
            fails++;
        end
        if (fails == 0) begin
            $display("pid_steering_delta_top_tb OK");
        end else begin
            $display("pid_steering_delta_top_tb NOT OK");
        end
        $finish;
    end

endmodule
